// ----- rtl/els_pkg.sv -----
// Shared constants, codes and widths for the easy leaf sum block.
package els_pkg;

  localparam int CNT_W = 13;
  localparam int PRM_W = 17;
  localparam int IDX_W = 16;
  localparam int VAL_W = 17;
  localparam int SUM_W = 48;
  localparam int WORD_W = 64;

  localparam int COUNT_TABLE_SIZE_DEF = 65536;
  localparam int PRIME_TABLE_SIZE_DEF = 8192;

  localparam logic [1:0] OP_PI_WRITE    = 2'd0;
  localparam logic [1:0] OP_PRIME_WRITE = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  localparam logic [1:0] REG_X_VALUE = 2'd0;
  localparam logic [1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [1:0] REG_Z_LIMIT = 2'd2;

endpackage

// ----- rtl/els_ram.sv -----
// Generic single write port RAM with one registered read port.
module els_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/els_div.sv -----
// Restoring divider, 64-bit dividend by a prime-sized divisor, one bit per cycle.
module els_div import els_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [PRM_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [WORD_W-1:0] num_q;
  logic [PRM_W-1:0]  rem_q;
  logic [PRM_W-1:0]  den_q;
  logic [PRM_W:0]    shifted;
  logic [PRM_W+1:0]  diff;

  assign shifted = {rem_q, num_q[WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= dividend_i;
        den_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (!diff[PRM_W+1]) begin
          rem_q <= diff[PRM_W-1:0];
          num_q <= {num_q[WORD_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[PRM_W-1:0];
          num_q <= {num_q[WORD_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- rtl/easy_leaf_sum.sv -----
// Top level of the easy leaf sum block: tables, sequencer and shared arithmetic.
//
// Input channel (in_valid_i/in_ready_o) carries operation, index and value.
// A pi write or prime write transaction updates its table and returns
// nothing. A compute transaction sums the easy leaves for prime index
// b and returns one result transaction on the output channel
// (out_valid_o/out_ready_i) holding the saturated contribution and b.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes x, y and z and
// is always ready.
// The block holds one compute item at a time; in_ready_o is low until it is
// done. Every 64-bit division goes through one shared restoring divider.
// Setup costs three divisions plus a 32-step square root and four table
// reads. Each leaf lookup costs one division and two table reads; each
// clustered run needs two lookups and each sparse leaf one.
// When the receiver stalls, the finished result waits in the output register
// and table writes may still be taken. Reset clears the control state and
// sets x to 0, y and z to 1; table contents stay undefined until written.
module easy_leaf_sum import els_pkg::*; #(
  parameter int COUNT_TABLE_SIZE = COUNT_TABLE_SIZE_DEF,
  parameter int PRIME_TABLE_SIZE = PRIME_TABLE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [WORD_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SUM_W-1:0]  contribution_o,
  output logic [IDX_W-1:0]  index_echo_o
);

  localparam int CW = $clog2(COUNT_TABLE_SIZE);
  localparam int PW = $clog2(PRIME_TABLE_SIZE);
  localparam int KW = 15;
  localparam int TW = 18;
  localparam int PRODW = 34;
  localparam int ACCW = SUM_W + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_BRD, S_BGOT, S_DQ, S_DT, S_DZ, S_SQ, S_GT, S_GC, S_GS,
    S_WTOP, S_WLOOP, S_WA1, S_WA2, S_WA3, S_WB1, S_WB2, S_WEND,
    S_SLOOP, S_SB, S_MUL, S_ADD, S_KP, S_KD, S_KW, S_KC, S_KR, S_OUT
  } state_e;

  state_e state_q, ret_q, mret_q;

  logic [WORD_W-1:0] x_q, z_q;
  logic [IDX_W-1:0]  y_q;
  logic [IDX_W-1:0]  b_q;
  logic [PRM_W-1:0]  pb_q;
  logic [WORD_W-1:0] q_q;
  logic [PRM_W-1:0]  triv_q, clus_q, spar_q;
  logic [WORD_W-1:0] sv_q, sr_q, sbit_q;
  logic [CNT_W-1:0]  top_q, pc_q, ps_q, res_q, c_q;
  logic [KW-1:0]     hi_q, lo_q;
  logic [TW-1:0]     ma_q;
  logic [KW-1:0]     mb_q;
  logic [PRODW-1:0]  prod_q;
  logic [SUM_W-1:0]  acc_q;
  logic              out_valid_q;
  logic [SUM_W-1:0]  contribution_q;
  logic [IDX_W-1:0]  echo_q;

  logic [PW-1:0]     p_addr_q;
  logic              p_oob_q;
  logic [CW-1:0]     c_addr_q;
  logic              c_oob_q;
  logic              div_start_q;
  logic              div_start_d;
  logic [WORD_W-1:0] div_n_q;
  logic [PRM_W-1:0]  div_d_q;
  logic              div_done;
  logic [WORD_W-1:0] div_quot;

  logic [PRM_W-1:0]  prm_rd;
  logic [CNT_W-1:0]  cnt_rd;
  logic              in_fire;
  logic [WORD_W-1:0] sq_t;
  logic [KW-1:0]     nh_c, nl_c;
  logic [TW-1:0]     term_c;
  logic [ACCW-1:0]   sum_c;

  function automatic logic [PRM_W-1:0] clamp_fn(input logic [PRM_W-1:0] lo,
                                                input logic [WORD_W-1:0] v,
                                                input logic [IDX_W-1:0] hi);
    logic [PRM_W-1:0] r;
    if (v < WORD_W'(lo)) begin
      r = lo;
    end else if (v > WORD_W'(hi)) begin
      r = PRM_W'(hi);
    end else begin
      r = v[PRM_W-1:0];
    end
    return r;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  els_ram #(.WIDTH(CNT_W), .DEPTH(COUNT_TABLE_SIZE)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && operation_i == OP_PI_WRITE &&
              32'(index_i) < 32'(COUNT_TABLE_SIZE)),
    .waddr_i (CW'(index_i)),
    .wdata_i (value_i[CNT_W-1:0]),
    .re_i    (state_q == S_KC),
    .raddr_i (c_addr_q),
    .rdata_o (cnt_rd)
  );

  els_ram #(.WIDTH(PRM_W), .DEPTH(PRIME_TABLE_SIZE)) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && operation_i == OP_PRIME_WRITE &&
              32'(index_i) < 32'(PRIME_TABLE_SIZE)),
    .waddr_i (PW'(index_i)),
    .wdata_i (value_i),
    .re_i    (state_q == S_BRD || state_q == S_KP),
    .raddr_i (p_addr_q),
    .rdata_o (prm_rd)
  );

  els_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_n_q),
    .divisor_i  (div_d_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign sq_t   = sr_q + sbit_q;
  assign term_c = TW'($signed({5'b0, res_q}) - $signed({2'b0, b_q}) + $signed(TW'(2)));
  assign sum_c  = $signed({2'b00, acc_q}) + $signed({{(ACCW-PRODW){prod_q[PRODW-1]}}, prod_q});

  assign div_start_d = (state_q == S_BGOT) || (state_q == S_KD) ||
                       (div_done && (state_q == S_DQ || state_q == S_DT));

  always_comb begin
    nh_c = {2'b00, res_q};
    if (nh_c + KW'(1) < lo_q) begin
      nh_c = lo_q - KW'(1);
    end
    if (nh_c >= hi_q) begin
      nh_c = hi_q - KW'(1);
    end
    nl_c = {2'b00, res_q} + KW'(1);
    if (nl_c > hi_q + KW'(1)) begin
      nl_c = hi_q + KW'(1);
    end
    if (nl_c <= lo_q) begin
      nl_c = lo_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      mret_q      <= S_IDLE;
      x_q         <= '0;
      y_q         <= IDX_W'(1);
      z_q         <= WORD_W'(1);
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= div_start_d;
      if (state_q != S_OUT && out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_X_VALUE: x_q <= cfg_data_i;
          REG_Y_LIMIT: y_q <= cfg_data_i[IDX_W-1:0];
          REG_Z_LIMIT: z_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && operation_i == OP_COMPUTE) begin
            b_q      <= index_i;
            acc_q    <= '0;
            p_addr_q <= PW'(index_i);
            p_oob_q  <= 32'(index_i) >= 32'(PRIME_TABLE_SIZE);
            state_q  <= S_BRD;
          end
        end
        S_BRD: state_q <= S_BGOT;
        S_BGOT: begin
          pb_q        <= p_oob_q ? '0 : prm_rd;
          div_n_q     <= x_q;
          div_d_q     <= p_oob_q ? '0 : prm_rd;
          state_q     <= S_DQ;
        end
        S_DQ: begin
          if (div_done) begin
            q_q         <= div_quot;
            div_n_q     <= div_quot;
            state_q     <= S_DT;
          end
        end
        S_DT: begin
          if (div_done) begin
            triv_q      <= (div_quot > WORD_W'(y_q)) ? PRM_W'(y_q) : div_quot[PRM_W-1:0];
            div_n_q     <= z_q;
            state_q     <= S_DZ;
          end
        end
        S_DZ: begin
          if (div_done) begin
            spar_q  <= clamp_fn(pb_q, div_quot, y_q);
            sv_q    <= q_q;
            sr_q    <= '0;
            sbit_q  <= WORD_W'(1) << 62;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (sbit_q == '0) begin
            clus_q   <= clamp_fn(pb_q, sr_q, y_q);
            c_addr_q <= CW'(triv_q);
            c_oob_q  <= 32'(triv_q) >= 32'(COUNT_TABLE_SIZE);
            ret_q    <= S_GT;
            state_q  <= S_KC;
          end else begin
            if (sv_q >= sq_t) begin
              sv_q <= sv_q - sq_t;
              sr_q <= (sr_q >> 1) + sbit_q;
            end else begin
              sr_q <= sr_q >> 1;
            end
            sbit_q <= sbit_q >> 2;
          end
        end
        S_GT: begin
          top_q    <= res_q;
          c_addr_q <= CW'(clus_q);
          c_oob_q  <= 32'(clus_q) >= 32'(COUNT_TABLE_SIZE);
          ret_q    <= S_GC;
          state_q  <= S_KC;
        end
        S_GC: begin
          pc_q     <= res_q;
          c_addr_q <= CW'(spar_q);
          c_oob_q  <= 32'(spar_q) >= 32'(COUNT_TABLE_SIZE);
          ret_q    <= S_GS;
          state_q  <= S_KC;
        end
        S_GS: begin
          ps_q    <= res_q;
          state_q <= S_WTOP;
        end
        S_WTOP: begin
          if (top_q > pc_q) begin
            hi_q    <= KW'(top_q);
            lo_q    <= KW'(pc_q) + KW'(1);
            state_q <= S_WLOOP;
          end else begin
            state_q <= S_SLOOP;
          end
        end
        S_WLOOP: begin
          if (lo_q <= hi_q) begin
            p_addr_q <= PW'(hi_q);
            p_oob_q  <= 32'(hi_q) >= 32'(PRIME_TABLE_SIZE);
            ret_q    <= S_WA1;
            state_q  <= S_KP;
          end else begin
            state_q <= S_WEND;
          end
        end
        S_WA1: begin
          c_q      <= res_q;
          p_addr_q <= PW'({2'b00, res_q} + KW'(1));
          p_oob_q  <= 32'({2'b00, res_q} + KW'(1)) >= 32'(PRIME_TABLE_SIZE);
          ret_q    <= S_WA2;
          state_q  <= S_KP;
        end
        S_WA2: begin
          ma_q    <= TW'($signed({5'b0, c_q}) - $signed({2'b0, b_q}) + $signed(TW'(2)));
          mb_q    <= hi_q - nh_c;
          hi_q    <= nh_c;
          mret_q  <= S_WA3;
          state_q <= S_MUL;
        end
        S_WA3: begin
          if (lo_q > hi_q) begin
            state_q <= S_WEND;
          end else begin
            p_addr_q <= PW'(lo_q);
            p_oob_q  <= 32'(lo_q) >= 32'(PRIME_TABLE_SIZE);
            ret_q    <= S_WB1;
            state_q  <= S_KP;
          end
        end
        S_WB1: begin
          c_q      <= res_q;
          p_addr_q <= PW'(res_q);
          p_oob_q  <= 32'(res_q) >= 32'(PRIME_TABLE_SIZE);
          ret_q    <= S_WB2;
          state_q  <= S_KP;
        end
        S_WB2: begin
          ma_q    <= TW'($signed({5'b0, c_q}) - $signed({2'b0, b_q}) + $signed(TW'(2)));
          mb_q    <= nl_c - lo_q;
          lo_q    <= nl_c;
          mret_q  <= S_WLOOP;
          state_q <= S_MUL;
        end
        S_WEND: begin
          top_q   <= pc_q;
          state_q <= S_SLOOP;
        end
        S_SLOOP: begin
          if (top_q > ps_q) begin
            p_addr_q <= PW'(top_q);
            p_oob_q  <= 32'(top_q) >= 32'(PRIME_TABLE_SIZE);
            ret_q    <= S_SB;
            state_q  <= S_KP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_SB: begin
          ma_q    <= term_c;
          mb_q    <= KW'(1);
          top_q   <= top_q - CNT_W'(1);
          mret_q  <= S_SLOOP;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= PRODW'($signed({{(PRODW-TW){ma_q[TW-1]}}, ma_q}) *
                            $signed({{(PRODW-KW){1'b0}}, mb_q}));
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (sum_c[ACCW-1]) begin
            acc_q <= '0;
          end else if (sum_c[ACCW-2:SUM_W] != '0) begin
            acc_q <= '1;
          end else begin
            acc_q <= sum_c[SUM_W-1:0];
          end
          state_q <= mret_q;
        end
        S_KP: state_q <= S_KD;
        S_KD: begin
          div_n_q     <= q_q;
          div_d_q     <= p_oob_q ? '0 : prm_rd;
          state_q     <= S_KW;
        end
        S_KW: begin
          if (div_done) begin
            c_addr_q <= div_quot[CW-1:0];
            c_oob_q  <= div_quot >= WORD_W'(COUNT_TABLE_SIZE);
            state_q  <= S_KC;
          end
        end
        S_KC: state_q <= S_KR;
        S_KR: begin
          res_q   <= c_oob_q ? '0 : cnt_rd;
          state_q <= ret_q;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            contribution_q <= acc_q;
            echo_q         <= b_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign contribution_o = contribution_q;
  assign index_echo_o   = echo_q;

endmodule
